FILE: rtl/isn_pkg.sv
`timescale 1ns / 1ps

package isn_pkg;

  localparam int RADICAND_W = 32;
  localparam int ROOT_W     = 17;
  localparam int S_TDATA_W  = 32;
  localparam int M_TDATA_W  = 24;

  typedef enum logic [2:0] {
    S_WAIT    = 3'd0,
    S_INIT    = 3'd1,
    S_DIV     = 3'd2,
    S_WAITDIV = 3'd3,
    S_AVG     = 3'd4,
    S_STEP    = 3'd5,
    S_OUT     = 3'd6
  } step_t;

  typedef enum logic [2:0] {
    COND_ALWAYS  = 3'd0,
    COND_IN      = 3'd1,
    COND_SMALL   = 3'd2,
    COND_DIVDONE = 3'd3,
    COND_QGE     = 3'd4,
    COND_OUTFREE = 3'd5
  } cond_t;

  typedef struct packed {
    logic ld_v;
    logic ld_g_half;
    logic ld_g_nxt;
    logic ld_nxt_v;
    logic ld_nxt_avg;
    logic div_start;
    logic ld_q;
    logic ld_out;
  } action_t;

  typedef struct packed {
    cond_t   cond;
    logic    gate;
    action_t act;
    step_t   tgt_t;
    step_t   tgt_f;
  } ctrl_word_t;

  // The microprogram. When gate is set the actions fire only when the
  // condition holds; otherwise they fire unconditionally.
  function automatic ctrl_word_t ctrl_rom(step_t pc);
    ctrl_word_t w;
    w = '0;
    w.cond  = COND_ALWAYS;
    w.tgt_t = S_WAIT;
    w.tgt_f = S_WAIT;
    case (pc)
      S_WAIT: begin
        w.cond     = COND_IN;
        w.gate     = 1'b1;
        w.act.ld_v = 1'b1;
        w.tgt_t    = S_INIT;
        w.tgt_f    = S_WAIT;
      end
      S_INIT: begin
        w.cond          = COND_SMALL;
        w.act.ld_g_half = 1'b1;
        w.act.ld_nxt_v  = 1'b1;
        w.tgt_t         = S_OUT;
        w.tgt_f         = S_DIV;
      end
      S_DIV: begin
        w.act.div_start = 1'b1;
        w.tgt_t         = S_WAITDIV;
        w.tgt_f         = S_WAITDIV;
      end
      S_WAITDIV: begin
        w.cond     = COND_DIVDONE;
        w.gate     = 1'b1;
        w.act.ld_q = 1'b1;
        w.tgt_t    = S_AVG;
        w.tgt_f    = S_WAITDIV;
      end
      S_AVG: begin
        w.cond           = COND_QGE;
        w.act.ld_nxt_avg = 1'b1;
        w.tgt_t          = S_OUT;
        w.tgt_f          = S_STEP;
      end
      S_STEP: begin
        w.act.ld_g_nxt = 1'b1;
        w.tgt_t        = S_DIV;
        w.tgt_f        = S_DIV;
      end
      S_OUT: begin
        w.cond       = COND_OUTFREE;
        w.gate       = 1'b1;
        w.act.ld_out = 1'b1;
        w.tgt_t      = S_WAIT;
        w.tgt_f      = S_OUT;
      end
      default: begin
        w.tgt_t = S_WAIT;
        w.tgt_f = S_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/isn_div.sv
`timescale 1ns / 1ps

module isn_div #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic [WIDTH-1:0] quotient,
  output logic             done
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] den;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             fits;

  always_comb begin
    trial = {rem, quo[WIDTH-1]};
    diff  = trial - {1'b0, den};
    fits  = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        rem  <= '0;
        quo  <= dividend;
        den  <= divisor;
        cnt  <= CW'(WIDTH);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
        quo <= {quo[WIDTH-2:0], fits};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

FILE: rtl/integer_sqrt_newton.sv
`timescale 1ns / 1ps

// Channel  Direction  Transfer when          tdata fields (lowest bit up)
// s_axis   in         s_tvalid && s_tready   radicand[31:0]
// m_axis   out        m_tvalid && m_tready   root[16:0], zero fill to 24 bits
//
// Each Newton pass is paced by the bit-serial divider that computes
// radicand / guess; radicands 0 and 1 skip the divider and go straight to
// the output step.
// Reset clears the step counter, the divider control and the output valid.
// A result waits in the output register while the next radicand is taken.

module integer_sqrt_newton #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [isn_pkg::S_TDATA_W-1:0] s_tdata,  // radicand[31:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [isn_pkg::M_TDATA_W-1:0] m_tdata   // root[16:0], zeros above
);

  import isn_pkg::*;

  localparam int W = DATA_WIDTH;

  step_t      pc;
  step_t      pc_next;
  ctrl_word_t cw;
  logic       cond_true;
  logic       fire;

  logic [W-1:0]      v;
  logic [W-1:0]      g;
  logic [W-1:0]      q;
  logic [W-1:0]      nxt;
  logic [W-1:0]      avg;
  logic [W-1:0]      div_q;
  logic              div_done;
  logic [ROOT_W-1:0] root;

  isn_div #(
    .WIDTH(W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (fire && cw.act.div_start),
    .dividend (v),
    .divisor  (g),
    .quotient (div_q),
    .done     (div_done)
  );

  always_comb begin
    cw = ctrl_rom(pc);
    case (cw.cond)
      COND_ALWAYS:  cond_true = 1'b1;
      COND_IN:      cond_true = s_tvalid;
      COND_SMALL:   cond_true = v <= W'(1);
      COND_DIVDONE: cond_true = div_done;
      COND_QGE:     cond_true = q >= g;
      COND_OUTFREE: cond_true = !m_tvalid || m_tready;
      default:      cond_true = 1'b1;
    endcase
    fire    = cond_true || !cw.gate;
    pc_next = cond_true ? cw.tgt_t : cw.tgt_f;
    avg     = (g >> 1) + (q >> 1) + W'(g[0] & q[0]);
  end

  assign s_tready = (cw.cond == COND_IN);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= S_WAIT;
      m_tvalid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (fire && cw.act.ld_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && cw.act.ld_v) begin
      v <= W'(s_tdata);
    end
    if (fire && cw.act.ld_g_half) begin
      g <= v >> 1;
    end else if (fire && cw.act.ld_g_nxt) begin
      g <= nxt;
    end
    if (fire && cw.act.ld_q) begin
      q <= div_q;
    end
    if (fire && cw.act.ld_nxt_v) begin
      nxt <= v;
    end else if (fire && cw.act.ld_nxt_avg) begin
      nxt <= avg;
    end
    if (fire && cw.act.ld_out) begin
      root <= ROOT_W'(nxt);
    end
  end

  assign m_tdata = M_TDATA_W'(root);

  a_accept_to_init : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (pc == S_INIT))
    else $error("accepted radicand did not start the program");

  a_guess_nonzero : assert property (@(posedge clk) disable iff (rst)
    (pc == S_DIV) |-> (g != '0))
    else $error("division started with a zero guess");

  a_done_in_wait : assert property (@(posedge clk) disable iff (rst)
    div_done |-> (pc == S_WAITDIV))
    else $error("divider finished outside its wait step");

  a_out_loaded : assert property (@(posedge clk) disable iff (rst)
    (pc == S_OUT && (!m_tvalid || m_tready)) |=> (m_tvalid && pc == S_WAIT))
    else $error("result not presented after the output step");

endmodule
